// ===== rtl/core/sorted_list_insert_remove_macros.svh =====
// Assertion macros used by the checker of the sorted list block.
// No dependencies.
`ifndef SORTED_LIST_INSERT_REMOVE_MACROS_SVH
`define SORTED_LIST_INSERT_REMOVE_MACROS_SVH

// same-cycle implication
`define SLRI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted list assertion failed");

// next-cycle implication
`define SLRI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted list assertion failed");

`endif

// ===== rtl/core/slri_pkg.sv =====
// Package for the sorted list block: field widths, command codes and the
// cell control struct. No dependencies.
package slri_pkg;

  localparam int VALUE_W = 32;
  localparam int COUNT_W = 5;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  typedef struct packed {
    logic cmp;   // compare all cells against the incoming value
    logic ins;   // shift right from the insert point, load the value
    logic rm;    // shift left from the matching entry
  } slri_ctrl_t;

endpackage

// ===== rtl/core/slri_if.sv =====
// Valid/ready channel interfaces for command and result transactions.
// Depends on slri_pkg.
interface slri_in_if;
  import slri_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      cmd;
  logic signed [VALUE_W-1:0] value;
  modport source (output valid, output cmd, output value, input ready);
  modport sink (input valid, input cmd, input value, output ready);
endinterface

interface slri_out_if;
  import slri_pkg::*;
  logic               valid;
  logic               ready;
  logic               ok;
  logic [COUNT_W-1:0] count;
  modport source (output valid, output ok, output count, input ready);
  modport sink (input valid, input ok, input count, output ready);
endinterface

// ===== rtl/core/slri_cell.sv =====
// One slot of the sorted chain: holds an entry and its valid bit, compares
// against a command value, shifts with its neighbors. Depends on slri_pkg.
module slri_cell (
  input  logic                               clk,
  input  logic                               rst_n,
  input  slri_pkg::slri_ctrl_t               ctrl,
  input  logic signed [slri_pkg::VALUE_W-1:0] cmp_value,
  input  logic signed [slri_pkg::VALUE_W-1:0] ins_value,
  input  logic                               left_less_now,
  input  logic                               left_less_r,
  input  logic signed [slri_pkg::VALUE_W-1:0] left_entry,
  input  logic                               left_valid,
  input  logic signed [slri_pkg::VALUE_W-1:0] right_entry,
  input  logic                               right_valid,
  output logic                               less_now,
  output logic                               less_q,
  output logic                               hit_q,
  output logic signed [slri_pkg::VALUE_W-1:0] entry,
  output logic                               valid
);
  import slri_pkg::*;

  logic signed [VALUE_W-1:0] entry_r, entry_nxt;
  logic                      valid_r, valid_nxt;
  logic                      less_r, hit_r;
  logic                      hit_now;

  assign less_now = valid_r && (entry_r < cmp_value);
  assign hit_now  = valid_r && !less_now && left_less_now && (entry_r == cmp_value);

  always_comb begin
    entry_nxt = entry_r;
    valid_nxt = valid_r;
    if (ctrl.ins && !less_r) begin
      if (left_less_r) begin
        entry_nxt = ins_value;
        valid_nxt = 1'b1;
      end else begin
        entry_nxt = left_entry;
        valid_nxt = left_valid;
      end
    end else if (ctrl.rm && !less_r) begin
      entry_nxt = right_entry;
      valid_nxt = right_valid;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
      less_r  <= 1'b0;
      hit_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (ctrl.cmp) begin
        less_r <= less_now;
        hit_r  <= hit_now;
      end
    end
  end

  assign less_q = less_r;
  assign hit_q  = hit_r;
  assign entry  = entry_r;
  assign valid  = valid_r;

endmodule

// ===== rtl/core/sorted_list_insert_remove.sv =====
// Top level of the sorted list: a chain of slri_cell slots plus the command
// sequencer and result register. Depends on slri_pkg, slri_if, slri_cell.
//
//   channel   dir   payload          handshake
//   in_if     in    cmd, value       valid/ready
//   out_if    out   ok, count        valid/ready
//
// Each command is handled in order: the accept cycle registers the compare flags of
// every cell, then the apply state shifts the chain and loads the result register.
// A new command is accepted on the cycle after the shift.
// If a previous result is still unclaimed, the shift cycle waits for out ready.
// Synchronous active-low reset empties the list; entry data is not cleared.
module sorted_list_insert_remove #(
  parameter int CAPACITY = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  slri_in_if.sink    in_if,
  slri_out_if.source out_if
);
  import slri_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_APPLY = 1'b1;

  logic                      state_r, state_nxt;
  logic                      cmd_r;
  logic signed [VALUE_W-1:0] value_r;
  logic [CW-1:0]             count_r;
  logic                      ok_r;
  logic                      out_valid_r;
  logic                      accept, apply, full, found;
  slri_ctrl_t                ctrl;

  logic signed [VALUE_W-1:0] entry [CAPACITY];
  logic [CAPACITY-1:0]       valid, less_now, less_q, hit_q;

  assign accept = in_if.valid && in_if.ready;
  assign apply  = (state_r == ST_APPLY) && (!out_valid_r || out_if.ready);
  assign full   = (count_r == CW'(CAPACITY));
  assign found  = |hit_q;

  assign ctrl.cmp = accept;
  assign ctrl.ins = apply && (cmd_r == CMD_INSERT) && !full;
  assign ctrl.rm  = apply && (cmd_r == CMD_REMOVE) && found;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                      l_less_now, l_less_r, l_valid, r_valid;
    logic signed [VALUE_W-1:0] l_entry, r_entry;

    if (i == 0) begin : g_first
      assign l_less_now = 1'b1;
      assign l_less_r   = 1'b1;
      assign l_entry    = '0;
      assign l_valid    = 1'b0;
    end else begin : g_mid
      assign l_less_now = less_now[i-1];
      assign l_less_r   = less_q[i-1];
      assign l_entry    = entry[i-1];
      assign l_valid    = valid[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign r_entry = '0;
      assign r_valid = 1'b0;
    end else begin : g_inner
      assign r_entry = entry[i+1];
      assign r_valid = valid[i+1];
    end

    slri_cell u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctrl         (ctrl),
      .cmp_value    (in_if.value),
      .ins_value    (value_r),
      .left_less_now(l_less_now),
      .left_less_r  (l_less_r),
      .left_entry   (l_entry),
      .left_valid   (l_valid),
      .right_entry  (r_entry),
      .right_valid  (r_valid),
      .less_now     (less_now[i]),
      .less_q       (less_q[i]),
      .hit_q        (hit_q[i]),
      .entry        (entry[i]),
      .valid        (valid[i])
    );
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (accept) state_nxt = ST_APPLY;
      ST_APPLY: if (apply) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= in_if.cmd;
      value_r <= in_if.value;
    end
    if (apply) ok_r <= ctrl.ins || ctrl.rm;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ctrl.ins) count_r <= count_r + CW'(1);
      else if (ctrl.rm) count_r <= count_r - CW'(1);
      if (apply) out_valid_r <= 1'b1;
      else if (out_if.ready) out_valid_r <= 1'b0;
    end
  end

  assign in_if.ready  = (state_r == ST_IDLE);
  assign out_if.valid = out_valid_r;
  assign out_if.ok    = ok_r;
  assign out_if.count = COUNT_W'(count_r);

endmodule

// ===== rtl/core/slri_checker.sv =====
// Port-level checks for the sorted list block, bound to the top level.
// Depends on sorted_list_insert_remove_macros.svh and slri_pkg.
`include "sorted_list_insert_remove_macros.svh"

module slri_checker #(
  parameter int CAPACITY = 16
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         out_ok,
  input logic [slri_pkg::COUNT_W-1:0] out_count
);
  import slri_pkg::*;

  `SLRI_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_ok) && $stable(out_count))
  `SLRI_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
  `SLRI_ASSERT_NOW(a_count_bound, clk, rst_n, out_valid, (CAPACITY > 31) || (int'(out_count) <= CAPACITY))

endmodule

bind sorted_list_insert_remove slri_checker #(.CAPACITY(CAPACITY)) u_slri_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_if.valid),
  .in_ready (in_if.ready),
  .out_valid(out_if.valid),
  .out_ready(out_if.ready),
  .out_ok   (out_if.ok),
  .out_count(out_if.count)
);
